// ===== design/thrs_pkg.sv =====
// Shared types and constants of the track hit region selector.
`default_nettype none
package thrs_pkg;

  localparam int KIND_W     = 2;
  localparam int REGION_W   = 3;
  localparam int STATION_W  = 2;
  localparam int LAYER_W    = 3;
  localparam int SECTOR_W   = 7;
  localparam int QUARTER_W  = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int MIN_W      = 8;
  localparam int TOTAL_W    = 8;
  localparam int SLOT_IDX_W = 6;

  localparam logic [KIND_W-1:0] KIND_INNER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OUTER = 2'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TOP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BOTTOM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIDE_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIDE_C = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REQ_BOX    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REQ_MODULE = 3'd5;

  typedef struct packed {
    logic       last;
    logic       base;
    logic       inner;
    logic [1:0] region;
    logic       outer;
    logic       half;
    logic       check;
  } tally_ctl_t;

endpackage
`default_nettype wire

// ===== design/thrs_if.sv =====
// Channel interfaces: hit input, result output and register write.
`default_nettype none
interface thrs_hit_if;
  logic                            valid;
  logic                            ready;
  logic [thrs_pkg::KIND_W-1:0]     hit_kind;
  logic [thrs_pkg::REGION_W-1:0]   inner_region;
  logic [thrs_pkg::STATION_W-1:0]  inner_station;
  logic [thrs_pkg::LAYER_W-1:0]    inner_layer;
  logic [thrs_pkg::SECTOR_W-1:0]   inner_sector;
  logic [thrs_pkg::QUARTER_W-1:0]  outer_quarter;
  logic                            last_hit;
  logic                            base_accept;

  modport source (
    output valid, hit_kind, inner_region, inner_station, inner_layer,
           inner_sector, outer_quarter, last_hit, base_accept,
    input  ready
  );
  modport sink (
    input  valid, hit_kind, inner_region, inner_station, inner_layer,
           inner_sector, outer_quarter, last_hit, base_accept,
    output ready
  );
endinterface

interface thrs_res_if;
  logic                          valid;
  logic                          ready;
  logic                          track_accepted;
  logic                          box_overlap;
  logic                          module_overlap;
  logic [thrs_pkg::TOTAL_W-1:0]  total_hits;

  modport source (
    output valid, track_accepted, box_overlap, module_overlap, total_hits,
    input  ready
  );
  modport sink (
    input  valid, track_accepted, box_overlap, module_overlap, total_hits,
    output ready
  );
endinterface

interface thrs_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [thrs_pkg::CFG_IDX_W-1:0]   index;
  logic [thrs_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/thrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module thrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== design/thrs_hit_stage.sv =====
// Hit decode, per-slot seen flags and sector table access.
`default_nettype none
module thrs_hit_stage #(
  parameter int LAYER_SLOTS = 48,
  parameter int SECTOR_BITS = 7
) (
  input  wire logic              clk,
  input  wire logic              rst,
  thrs_hit_if.sink               hit,
  input  wire logic              hold,
  output logic                   s1_valid,
  output thrs_pkg::tally_ctl_t   s1_ctl,
  output logic [SECTOR_BITS-1:0] s1_sector,
  output logic [SECTOR_BITS-1:0] s1_stored
);

  localparam int AW = $clog2(LAYER_SLOTS);

  logic                                 accept;
  logic                                 is_inner;
  logic                                 geo_ok;
  logic                                 slot_ok;
  logic                                 slot;
  logic                                 was_seen;
  logic [1:0]                           region_idx;
  logic [thrs_pkg::SLOT_IDX_W-1:0]      idx;
  logic [AW-1:0]                        addr;
  logic [SECTOR_BITS-1:0]               sector;
  logic [LAYER_SLOTS-1:0]               seen;

  assign hit.ready = !hold;
  assign accept    = hit.valid && hit.ready;

  assign is_inner   = (hit.hit_kind == thrs_pkg::KIND_INNER) &&
                      (hit.inner_region >= 3'd1) && (hit.inner_region <= 3'd4);
  assign region_idx = 2'(hit.inner_region - 3'd1);
  assign geo_ok     = (hit.inner_station != 2'd0) &&
                      (hit.inner_layer >= 3'd1) && (hit.inner_layer <= 3'd4);
  assign idx        = {2'(hit.inner_station - 2'd1), 2'(hit.inner_layer - 3'd1),
                       region_idx};
  assign slot_ok    = {1'b0, idx} < 7'(LAYER_SLOTS);
  assign slot       = is_inner && geo_ok && slot_ok;
  assign addr       = idx[AW-1:0];
  assign was_seen   = seen[addr];
  assign sector     = SECTOR_BITS'(hit.inner_sector);

  thrs_ram #(
    .WIDTH (SECTOR_BITS),
    .DEPTH (LAYER_SLOTS)
  ) u_sector_ram (
    .clk   (clk),
    .we    (accept && slot && !was_seen),
    .waddr (addr),
    .wdata (sector),
    .re    (accept && slot && was_seen),
    .raddr (addr),
    .rdata (s1_stored)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (accept) begin
      if (hit.last_hit) begin
        seen <= '0;
      end else if (slot) begin
        seen[addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!hold) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl.last   <= hit.last_hit;
      s1_ctl.base   <= hit.base_accept;
      s1_ctl.inner  <= is_inner;
      s1_ctl.region <= region_idx;
      s1_ctl.outer  <= (hit.hit_kind == thrs_pkg::KIND_OUTER);
      s1_ctl.half   <= hit.outer_quarter[0];
      s1_ctl.check  <= slot && was_seen;
      s1_sector     <= sector;
    end
  end

endmodule
`default_nettype wire

// ===== design/thrs_tally.sv =====
// Saturating hit counters, overlap flag and end-of-track snapshot.
`default_nettype none
module thrs_tally #(
  parameter int COUNT_BITS  = 8,
  parameter int SECTOR_BITS = 7
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s1_valid,
  input  wire thrs_pkg::tally_ctl_t       s1_ctl,
  input  wire logic [SECTOR_BITS-1:0]     s1_sector,
  input  wire logic [SECTOR_BITS-1:0]     s1_stored,
  input  wire logic                       out_free,
  output logic                            hold,
  output logic                            s2_valid,
  output logic [3:0][COUNT_BITS-1:0]      s2_region,
  output logic [1:0][COUNT_BITS-1:0]      s2_half,
  output logic                            s2_overlap,
  output logic                            s2_base
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [3:0][COUNT_BITS-1:0] region_cnt;
  logic [3:0][COUNT_BITS-1:0] region_next;
  logic [1:0][COUNT_BITS-1:0] half_cnt;
  logic [1:0][COUNT_BITS-1:0] half_next;
  logic                       overlap;
  logic                       overlap_next;
  logic                       fire;

  assign hold = s1_valid && s1_ctl.last && s2_valid && !out_free;
  assign fire = s1_valid && !hold;

  always_comb begin
    region_next = region_cnt;
    half_next   = half_cnt;
    if (s1_ctl.inner && region_cnt[s1_ctl.region] != COUNT_MAX) begin
      region_next[s1_ctl.region] = region_cnt[s1_ctl.region] + COUNT_BITS'(1);
    end
    if (s1_ctl.outer && half_cnt[s1_ctl.half] != COUNT_MAX) begin
      half_next[s1_ctl.half] = half_cnt[s1_ctl.half] + COUNT_BITS'(1);
    end
    overlap_next = overlap || (s1_ctl.check && (s1_stored != s1_sector));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      region_cnt <= '0;
      half_cnt   <= '0;
      overlap    <= 1'b0;
    end else if (fire) begin
      if (s1_ctl.last) begin
        region_cnt <= '0;
        half_cnt   <= '0;
        overlap    <= 1'b0;
      end else begin
        region_cnt <= region_next;
        half_cnt   <= half_next;
        overlap    <= overlap_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (fire && s1_ctl.last) begin
      s2_valid <= 1'b1;
    end else if (out_free) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1_ctl.last) begin
      s2_region  <= region_next;
      s2_half    <= half_next;
      s2_overlap <= overlap_next;
      s2_base    <= s1_ctl.base;
    end
  end

endmodule
`default_nettype wire

// ===== design/thrs_decide.sv =====
// Selection registers and the registered track decision.
`default_nettype none
module thrs_decide #(
  parameter int COUNT_BITS = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  thrs_cfg_if.sink                         cfg,
  thrs_res_if.source                       res,
  input  wire logic                        s2_valid,
  input  wire logic [3:0][COUNT_BITS-1:0]  s2_region,
  input  wire logic [1:0][COUNT_BITS-1:0]  s2_half,
  input  wire logic                        s2_overlap,
  input  wire logic                        s2_base,
  output logic                             out_free
);

  localparam int SW  = COUNT_BITS + 3;
  localparam int CW  = (COUNT_BITS > thrs_pkg::MIN_W) ? COUNT_BITS : thrs_pkg::MIN_W;
  localparam int SAT = (COUNT_BITS < thrs_pkg::TOTAL_W) ? (2 ** COUNT_BITS - 1) : 255;

  logic [thrs_pkg::MIN_W-1:0]   min_top;
  logic [thrs_pkg::MIN_W-1:0]   min_bottom;
  logic [thrs_pkg::MIN_W-1:0]   min_side_a;
  logic [thrs_pkg::MIN_W-1:0]   min_side_c;
  logic                         req_box;
  logic                         req_module;

  logic [SW-1:0]                sum;
  logic [5:0]                   nonzero;
  logic [2:0]                   nz_count;
  logic                         box;
  logic                         mins_ok;
  logic                         mode_ok;
  logic [thrs_pkg::TOTAL_W-1:0] total;

  assign cfg.ready = 1'b1;
  assign out_free  = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_top    <= '0;
      min_bottom <= '0;
      min_side_a <= '0;
      min_side_c <= '0;
      req_box    <= 1'b0;
      req_module <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        thrs_pkg::CFG_MIN_TOP:    min_top    <= cfg.data;
        thrs_pkg::CFG_MIN_BOTTOM: min_bottom <= cfg.data;
        thrs_pkg::CFG_MIN_SIDE_A: min_side_a <= cfg.data;
        thrs_pkg::CFG_MIN_SIDE_C: min_side_c <= cfg.data;
        thrs_pkg::CFG_REQ_BOX:    req_box    <= cfg.data[0];
        thrs_pkg::CFG_REQ_MODULE: req_module <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sum = SW'(s2_region[0]) + SW'(s2_region[1]) + SW'(s2_region[2]) +
          SW'(s2_region[3]) + SW'(s2_half[0]) + SW'(s2_half[1]);
    nonzero = {s2_region[0] != '0, s2_region[1] != '0, s2_region[2] != '0,
               s2_region[3] != '0, s2_half[0] != '0, s2_half[1] != '0};
    nz_count = 3'($countones(nonzero));
    box      = nz_count >= 3'd2;
    total    = (sum > SW'(SAT)) ? thrs_pkg::TOTAL_W'(SAT) : thrs_pkg::TOTAL_W'(sum);
    mins_ok  = (CW'(s2_region[3]) >= CW'(min_top)) &&
               (CW'(s2_region[2]) >= CW'(min_bottom)) &&
               (CW'(s2_region[1]) >= CW'(min_side_a)) &&
               (CW'(s2_region[0]) >= CW'(min_side_c));
    mode_ok  = (req_box && box) || (req_module && s2_overlap) ||
               (!req_box && !req_module);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_free) begin
      res.valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_valid) begin
      res.track_accepted <= mins_ok && mode_ok && s2_base;
      res.box_overlap    <= box;
      res.module_overlap <= s2_overlap;
      res.total_hits     <= total;
    end
  end

endmodule
`default_nettype wire

// ===== design/track_hit_region_selector.sv =====
// Top level of the track hit region selector.
//
//   port  role     beat
//   hit   sink     one hit of a track (kind, inner address, quarter, last, base)
//   res   source   one decision per track, after its last hit
//   cfg   sink     one selection register write (index, data)
//
// Takes one hit per cycle unless a stalled result holds the input. A decision
// leaves through the sector table read, counter snapshot and decision register.
// A stalled result stops the input once the next last hit reaches the
// counters; hits ahead of that last hit keep flowing.
// Reset clears counters, seen flags, valid flags and selection registers; sector table is not cleared.
`default_nettype none
module track_hit_region_selector #(
  parameter int LAYER_SLOTS = 48,
  parameter int SECTOR_BITS = 7,
  parameter int COUNT_BITS  = 8
) (
  input  wire logic  clk,
  input  wire logic  rst,
  thrs_hit_if.sink   hit,
  thrs_res_if.source res,
  thrs_cfg_if.sink   cfg
);

  logic                       hold;
  logic                       out_free;
  logic                       s1_valid;
  thrs_pkg::tally_ctl_t       s1_ctl;
  logic [SECTOR_BITS-1:0]     s1_sector;
  logic [SECTOR_BITS-1:0]     s1_stored;
  logic                       s2_valid;
  logic [3:0][COUNT_BITS-1:0] s2_region;
  logic [1:0][COUNT_BITS-1:0] s2_half;
  logic                       s2_overlap;
  logic                       s2_base;

  thrs_hit_stage #(
    .LAYER_SLOTS (LAYER_SLOTS),
    .SECTOR_BITS (SECTOR_BITS)
  ) u_hit_stage (
    .clk       (clk),
    .rst       (rst),
    .hit       (hit),
    .hold      (hold),
    .s1_valid  (s1_valid),
    .s1_ctl    (s1_ctl),
    .s1_sector (s1_sector),
    .s1_stored (s1_stored)
  );

  thrs_tally #(
    .COUNT_BITS  (COUNT_BITS),
    .SECTOR_BITS (SECTOR_BITS)
  ) u_tally (
    .clk        (clk),
    .rst        (rst),
    .s1_valid   (s1_valid),
    .s1_ctl     (s1_ctl),
    .s1_sector  (s1_sector),
    .s1_stored  (s1_stored),
    .out_free   (out_free),
    .hold       (hold),
    .s2_valid   (s2_valid),
    .s2_region  (s2_region),
    .s2_half    (s2_half),
    .s2_overlap (s2_overlap),
    .s2_base    (s2_base)
  );

  thrs_decide #(
    .COUNT_BITS (COUNT_BITS)
  ) u_decide (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .res        (res),
    .s2_valid   (s2_valid),
    .s2_region  (s2_region),
    .s2_half    (s2_half),
    .s2_overlap (s2_overlap),
    .s2_base    (s2_base),
    .out_free   (out_free)
  );

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the track hit region selector: hit tracks in, decisions predicted.
`timescale 1ns / 1ps
module testbench;

  localparam logic [thrs_pkg::KIND_W-1:0]    KIND_IN      = thrs_pkg::KIND_INNER;
  localparam logic [thrs_pkg::KIND_W-1:0]    KIND_OUT     = thrs_pkg::KIND_OUTER;
  localparam logic [thrs_pkg::KIND_W-1:0]    KIND_NONE    = 2'd2;
  localparam logic [thrs_pkg::KIND_W-1:0]    KIND_SPARE   = 2'd3;
  localparam logic [thrs_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [thrs_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam int SLOTS       = 48;
  localparam int COUNT_MAX   = 255;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 8;
  localparam int PHASE_HITS  = 100;
  localparam int PHASES      = 7;
  localparam int ROTATE_HITS = 300;
  localparam int MODE_NORMAL = 0;
  localparam int MODE_ROTATE = 5;

  typedef struct packed {
    bit [thrs_pkg::KIND_W-1:0]    kind;
    bit [thrs_pkg::REGION_W-1:0]  region;
    bit [thrs_pkg::STATION_W-1:0] station;
    bit [thrs_pkg::LAYER_W-1:0]   layer;
    bit [thrs_pkg::SECTOR_W-1:0]  sector;
    bit [thrs_pkg::QUARTER_W-1:0] quarter;
    bit                           last;
    bit                           base;
  } hit_t;

  typedef struct packed {
    bit                         accepted;
    bit                         box;
    bit                         modov;
    bit [thrs_pkg::TOTAL_W-1:0] total;
  } decision_t;

  typedef struct packed {
    hit_t      h;
    bit        typed;
    decision_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  thrs_hit_if hit_ch ();
  thrs_res_if res_ch ();
  thrs_cfg_if cfg_ch ();

  track_hit_region_selector dut (
    .clk(clk),
    .rst(rst),
    .hit(hit_ch),
    .res(res_ch),
    .cfg(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bit [thrs_pkg::MIN_W-1:0]    min_top, min_bottom, min_side_a, min_side_c;
  bit                          need_box, need_modov;
  bit [7:0]                    region_hits [4];
  bit [7:0]                    half_hits [2];
  bit [thrs_pkg::SECTOR_W-1:0] slot_sector [SLOTS];
  bit                          slot_seen [SLOTS];
  bit                          overlap_seen;

  decision_t pending_decisions [$];
  bit        quiet;
  int        errors;
  int        hits_sent;
  int        decisions_seen;
  int        settings_written;
  int        idle_cycles;

  row_t directed_rows [20] = '{
    '{'{KIND_NONE,  3'd0, 2'd0, 3'd0, 7'd0,   2'd0, 1'b1, 1'b1}, 1'b1, '{1'b1, 1'b0, 1'b0, 8'd0}},
    '{'{KIND_NONE,  3'd7, 2'd3, 3'd7, 7'd127, 2'd3, 1'b1, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0, 8'd0}},
    '{'{KIND_SPARE, 3'd0, 2'd0, 3'd0, 7'd0,   2'd0, 1'b1, 1'b1}, 1'b1, '{1'b1, 1'b0, 1'b0, 8'd0}},
    '{'{KIND_IN,    3'd1, 2'd1, 3'd1, 7'd0,   2'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{KIND_IN,    3'd1, 2'd1, 3'd1, 7'd127, 2'd0, 1'b1, 1'b1}, 1'b1, '{1'b1, 1'b0, 1'b1, 8'd2}},
    '{'{KIND_IN,    3'd0, 2'd1, 3'd1, 7'd5,   2'd0, 1'b1, 1'b1}, 1'b1, '{1'b1, 1'b0, 1'b0, 8'd0}},
    '{'{KIND_IN,    3'd7, 2'd2, 3'd2, 7'd5,   2'd0, 1'b1, 1'b1}, 1'b1, '{1'b1, 1'b0, 1'b0, 8'd0}},
    '{'{KIND_IN,    3'd4, 2'd0, 3'd1, 7'd9,   2'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{KIND_IN,    3'd4, 2'd3, 3'd4, 7'd5,   2'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{KIND_IN,    3'd4, 2'd3, 3'd4, 7'd5,   2'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{KIND_OUT,   3'd0, 2'd0, 3'd0, 7'd0,   2'd3, 1'b1, 1'b1}, 1'b1, '{1'b1, 1'b1, 1'b0, 8'd4}},
    '{'{KIND_IN,    3'd2, 2'd3, 3'd7, 7'd0,   2'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{KIND_IN,    3'd3, 2'd2, 3'd0, 7'd1,   2'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{KIND_OUT,   3'd7, 2'd3, 3'd7, 7'd127, 2'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{KIND_OUT,   3'd0, 2'd0, 3'd0, 7'd0,   2'd2, 1'b0, 1'b0}, 1'b0, '0},
    '{'{KIND_NONE,  3'd0, 2'd0, 3'd0, 7'd0,   2'd0, 1'b1, 1'b0}, 1'b1, '{1'b0, 1'b1, 1'b0, 8'd4}},
    '{'{KIND_IN,    3'd3, 2'd3, 3'd3, 7'd64,  2'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{KIND_IN,    3'd3, 2'd3, 3'd3, 7'd65,  2'd0, 1'b1, 1'b1}, 1'b1, '{1'b1, 1'b0, 1'b1, 8'd2}},
    '{'{KIND_IN,    3'd2, 2'd2, 3'd3, 7'd10,  2'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{KIND_OUT,   3'd0, 2'd0, 3'd0, 7'd0,   2'd1, 1'b1, 1'b1}, 1'b0, '0}
  };

  function automatic bit [7:0] sat_inc(input bit [7:0] count);
    return (count == 8'(COUNT_MAX)) ? count : count + 8'd1;
  endfunction

  function automatic bit tally_hit(input hit_t h, output decision_t d);
    int slot;
    int nonzero;
    int sum;
    nonzero = 0;
    sum = 0;
    d = '0;
    if (h.kind == KIND_IN && h.region >= 3'd1 && h.region <= 3'd4) begin
      region_hits[h.region - 3'd1] = sat_inc(region_hits[h.region - 3'd1]);
      if (h.station >= 2'd1 && h.station <= 2'd3 && h.layer >= 3'd1 && h.layer <= 3'd4) begin
        slot = (int'(h.region) - 1) + 4 * ((int'(h.layer) - 1) + 4 * (int'(h.station) - 1));
        if (slot < SLOTS) begin
          if (!slot_seen[slot]) begin
            slot_seen[slot] = 1'b1;
            slot_sector[slot] = h.sector;
          end else if (slot_sector[slot] != h.sector) begin
            overlap_seen = 1'b1;
          end
        end
      end
    end else if (h.kind == KIND_OUT) begin
      half_hits[h.quarter[0]] = sat_inc(half_hits[h.quarter[0]]);
    end
    if (!h.last) return 1'b0;
    foreach (region_hits[r]) begin
      sum += region_hits[r];
      if (region_hits[r] != 0) nonzero++;
    end
    foreach (half_hits[q]) begin
      sum += half_hits[q];
      if (half_hits[q] != 0) nonzero++;
    end
    if (sum > COUNT_MAX) sum = COUNT_MAX;
    d.box = (nonzero >= 2);
    d.modov = overlap_seen;
    d.total = 8'(sum);
    d.accepted = region_hits[3] >= min_top && region_hits[2] >= min_bottom &&
                 region_hits[1] >= min_side_a && region_hits[0] >= min_side_c && h.base &&
                 ((need_box && d.box) || (need_modov && overlap_seen) ||
                  (!need_box && !need_modov));
    region_hits = '{default: '0};
    half_hits = '{default: '0};
    slot_seen = '{default: 1'b0};
    overlap_seen = 1'b0;
    return 1'b1;
  endfunction

  task automatic send_hit(input hit_t h, input bit typed, input decision_t typed_want);
    int gap;
    decision_t d;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      if (hit_ch.valid) hit_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    hit_ch.valid         <= 1'b1;
    hit_ch.hit_kind      <= h.kind;
    hit_ch.inner_region  <= h.region;
    hit_ch.inner_station <= h.station;
    hit_ch.inner_layer   <= h.layer;
    hit_ch.inner_sector  <= h.sector;
    hit_ch.outer_quarter <= h.quarter;
    hit_ch.last_hit      <= h.last;
    hit_ch.base_accept   <= h.base;
    @(posedge clk);
    while (!hit_ch.ready) @(posedge clk);
    hits_sent++;
    if (tally_hit(h, d)) begin
      pending_decisions.insert(pending_decisions.size(), typed ? typed_want : d);
    end
  endtask

  task automatic wait_idle();
    if (hit_ch.valid) hit_ch.valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [thrs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [thrs_pkg::CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      thrs_pkg::CFG_MIN_TOP:    min_top = value;
      thrs_pkg::CFG_MIN_BOTTOM: min_bottom = value;
      thrs_pkg::CFG_MIN_SIDE_A: min_side_a = value;
      thrs_pkg::CFG_MIN_SIDE_C: min_side_c = value;
      thrs_pkg::CFG_REQ_BOX:    need_box = value[0];
      thrs_pkg::CFG_REQ_MODULE: need_modov = value[0];
      default: ;
    endcase
  endtask

  task automatic program_selection(input bit [7:0] top, input bit [7:0] bottom,
                                   input bit [7:0] side_a, input bit [7:0] side_c,
                                   input bit box, input bit modov);
    cfg_write(thrs_pkg::CFG_MIN_TOP, top);
    cfg_write(thrs_pkg::CFG_MIN_BOTTOM, bottom);
    cfg_write(thrs_pkg::CFG_MIN_SIDE_A, side_a);
    cfg_write(thrs_pkg::CFG_MIN_SIDE_C, side_c);
    cfg_write(thrs_pkg::CFG_REQ_BOX, {7'($urandom), box});
    cfg_write(thrs_pkg::CFG_REQ_MODULE, {7'($urandom), modov});
    cfg_write(CFG_SPARE_LO, 8'($urandom));
    cfg_write(CFG_SPARE_HI, 8'($urandom));
    cfg_ch.valid <= 1'b0;
    settings_written++;
  endtask

  task automatic run_track(input int n_hits, input int mode);
    hit_t                        h;
    bit                          noisy;
    bit                          narrow;
    int                          pool;
    int                          roll;
    int                          i;
    bit [thrs_pkg::SECTOR_W-1:0] sector_base;
    noisy = ($urandom_range(0, 9) == 0);
    narrow = 1'($urandom_range(0, 1));
    pool = $urandom_range(0, 3);
    sector_base = 7'($urandom);
    quiet = ($urandom_range(0, 3) == 0);
    for (i = 0; i < n_hits; i++) begin
      roll = $urandom_range(0, 99);
      if (mode != MODE_NORMAL) h.kind = KIND_IN;
      else if (roll < 65) h.kind = KIND_IN;
      else if (roll < 88) h.kind = KIND_OUT;
      else if (roll < 95) h.kind = KIND_NONE;
      else h.kind = KIND_SPARE;
      if (noisy) begin
        h.region = 3'($urandom);
        h.station = 2'($urandom);
        h.layer = 3'($urandom);
        h.sector = 7'($urandom);
      end else begin
        h.region = 3'($urandom_range(1, 4));
        h.station = narrow ? 2'd1 : 2'($urandom_range(1, 3));
        h.layer = narrow ? 3'($urandom_range(1, 2)) : 3'($urandom_range(1, 4));
        h.sector = sector_base + 7'($urandom_range(0, pool));
      end
      if (mode == MODE_ROTATE) h.region = 3'(i % 4 + 1);
      else if (mode != MODE_NORMAL) h.region = 3'(mode);
      h.quarter = 2'($urandom);
      h.last = (i == n_hits - 1);
      h.base = ($urandom_range(0, 3) != 0);
      send_hit(h, 1'b0, '0);
    end
  endtask

  initial begin
    int        stall;
    decision_t want;
    res_ch.ready = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
      decisions_seen++;
      if (pending_decisions.size() == 0) begin
        $error("decision beat with no track pending");
        errors++;
      end else begin
        want = pending_decisions.pop_front();
        if (res_ch.track_accepted !== want.accepted) begin
          $error("track_accepted: expected %0d, got %0d", want.accepted, res_ch.track_accepted);
          errors++;
        end
        if (res_ch.box_overlap !== want.box) begin
          $error("box_overlap: expected %0d, got %0d", want.box, res_ch.box_overlap);
          errors++;
        end
        if (res_ch.module_overlap !== want.modov) begin
          $error("module_overlap: expected %0d, got %0d", want.modov, res_ch.module_overlap);
          errors++;
        end
        if (res_ch.total_hits !== want.total) begin
          $error("total_hits: expected %0d, got %0d", want.total, res_ch.total_hits);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((hit_ch.valid && hit_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int ph;
    int phase_start;
    bit paused;
    hit_ch.valid         = 1'b0;
    hit_ch.hit_kind      = '0;
    hit_ch.inner_region  = '0;
    hit_ch.inner_station = '0;
    hit_ch.inner_layer   = '0;
    hit_ch.inner_sector  = '0;
    hit_ch.outer_quarter = '0;
    hit_ch.last_hit      = 1'b0;
    hit_ch.base_accept   = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = '0;
    cfg_ch.data          = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      send_hit(directed_rows[r].h, directed_rows[r].typed, directed_rows[r].want);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: program_selection(8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0);
        1: program_selection(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1);
        2: program_selection(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                             8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)), 1'b0, 1'b1);
        3: program_selection(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                             8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)), 1'b1, 1'b1);
        4: program_selection(8'd1, 8'd1, 8'd1, 8'd1, 1'b0, 1'b0);
        5: program_selection(8'($urandom_range(0, 2)), 8'($urandom),
                             8'($urandom_range(0, 2)), 8'($urandom_range(0, 1)),
                             1'($urandom), 1'($urandom));
        default: program_selection(8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
      endcase
      if (ph == 1) run_track(ROTATE_HITS, MODE_ROTATE);
      phase_start = hits_sent;
      paused = 1'b0;
      while (hits_sent - phase_start < PHASE_HITS) begin
        if ($urandom_range(0, 39) == 0) run_track($urandom_range(256, 300), $urandom_range(1, 4));
        else run_track($urandom_range(1, 12), MODE_NORMAL);
        if (!paused && hits_sent - phase_start >= PHASE_HITS / 2) begin
          wait_idle();
          paused = 1'b1;
        end
      end
    end
    wait_idle();

    $display("covered %0d hits and %0d track decisions over %0d register settings",
             hits_sent, decisions_seen, settings_written);
    $display("settings included zero and full minimums and every overlap mode");
    if (errors == 0 && pending_decisions.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/thrs_pkg.sv
design/thrs_if.sv
design/thrs_ram.sv
design/thrs_hit_stage.sv
design/thrs_tally.sv
design/thrs_decide.sv
design/track_hit_region_selector.sv
verif/testbench.sv
